FILE: src/acpi_ec_pkg.sv
// Shared types, codes and sizes for the embedded-controller host interface.
// No dependencies; every other source file but acpi_ec_checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package acpi_ec_pkg;

    // Query FIFO geometry
    localparam int QUERY_DEPTH = 8;
    localparam int QUERY_AW    = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
    localparam int QUERY_CW    = $clog2(QUERY_DEPTH + 1);

    // Controller space geometry (fixed by the 8-bit address)
    localparam int SPACE_AW    = 8;
    localparam int SPACE_DEPTH = 1 << SPACE_AW;

    typedef enum logic [2:0] {
        OP_RD_STATUS  = 3'd0,
        OP_WR_CMD     = 3'd1,
        OP_RD_DATA    = 3'd2,
        OP_WR_DATA    = 3'd3,
        OP_POST_QUERY = 3'd4,
        OP_LOCAL_WR   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_RD_ADDR  = 2'd1,
        PH_WR_ADDR  = 2'd2,
        PH_WR_VALUE = 2'd3
    } t_phase;

    localparam logic [7:0] CMD_READ      = 8'h80;
    localparam logic [7:0] CMD_WRITE     = 8'h81;
    localparam logic [7:0] CMD_BURST_ON  = 8'h82;
    localparam logic [7:0] CMD_BURST_OFF = 8'h83;
    localparam logic [7:0] CMD_QUERY     = 8'h84;
    localparam logic [7:0] BURST_GRANT   = 8'h90;

    // Status byte bit positions
    localparam int ST_OBF_BIT   = 0;
    localparam int ST_IBF_BIT   = 1;
    localparam int ST_BURST_BIT = 4;
    localparam int ST_SCI_BIT   = 5;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qf_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
        logic last;
    } t_qf_stat;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_sp_ctrl;

endpackage : acpi_ec_pkg

`default_nettype wire

FILE: src/acpi_ec_space.sv
// 256-byte controller space: one write port, one registered read port.
// Per-entry valid bits make never-written bytes read as zero. Uses acpi_ec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acpi_ec_space (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire acpi_ec_pkg::t_sp_ctrl          i_ctrl,
    input  wire logic [acpi_ec_pkg::SPACE_AW-1:0] i_waddr,
    input  wire logic [7:0]                     i_wdata,
    input  wire logic [acpi_ec_pkg::SPACE_AW-1:0] i_raddr,
    output logic      [7:0]                     o_rdata
);
    import acpi_ec_pkg::*;

    logic [7:0]             r_mem [SPACE_DEPTH];
    logic [SPACE_DEPTH-1:0] r_vld;
    logic [7:0]             r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctrl.wr_en) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : 8'h00;

endmodule : acpi_ec_space

`default_nettype wire

FILE: src/acpi_ec_qfifo.sv
// Circular FIFO of pending query indices with head pointer and fill count.
// Uses acpi_ec_pkg for depth and control/status structs.
`timescale 1ns / 1ps
`default_nettype none

module acpi_ec_qfifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire acpi_ec_pkg::t_qf_ctrl i_ctrl,
    input  wire logic [7:0]            i_wdata,
    output logic      [7:0]            o_head_data,
    output acpi_ec_pkg::t_qf_stat      o_stat
);
    import acpi_ec_pkg::*;

    localparam int SW = QUERY_CW + 1;
    localparam logic [SW-1:0]       DEPTH_S = SW'(QUERY_DEPTH);
    localparam logic [QUERY_AW-1:0] LAST_IX = QUERY_AW'(QUERY_DEPTH - 1);

    logic [7:0]          r_mem [QUERY_DEPTH];
    logic [QUERY_AW-1:0] r_head;
    logic [QUERY_CW-1:0] r_count;
    logic [SW-1:0]       w_sum;
    logic [QUERY_AW-1:0] w_tail;

    // Tail = (head + count) mod depth; the sum stays below twice the depth
    always_comb begin
        w_sum  = SW'(r_head) + SW'(r_count);
        w_tail = (w_sum >= DEPTH_S) ? QUERY_AW'(w_sum - DEPTH_S) : QUERY_AW'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[w_tail] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + QUERY_CW'(1);
        end else if (i_ctrl.pop) begin
            r_count <= r_count - QUERY_CW'(1);
            r_head  <= (r_head == LAST_IX) ? '0 : r_head + QUERY_AW'(1);
        end
    end

    assign o_head_data  = r_mem[r_head];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QUERY_CW'(QUERY_DEPTH));
    assign o_stat.last  = (r_count == QUERY_CW'(1));

endmodule : acpi_ec_qfifo

`default_nettype wire

FILE: src/acpi_embedded_controller_interface.sv
// Top level of the embedded-controller host interface (device side).
// Depends on acpi_ec_pkg, acpi_ec_space and acpi_ec_qfifo.
//
//   channel  | valid    | stall    | payload
//   ---------+----------+----------+------------------------------------------
//   input    | i_valid  | o_stall  | i_opcode, i_local_address, i_data_in
//   output   | o_valid  | i_stall  | o_read_data, o_sci_pending, o_protocol_error
//
// One beat per cycle sustained while the output is not stalled: the input
// register feeds the protocol logic, whose answer is registered in the
// result register. Throughput is set by the single space write port and
// single read port, each used at most once per beat.
// Reset (synchronous, active low) clears all control state; the
// 256 space bytes carry per-byte valid bits, so no clearing pass is needed.
// A stall on the output holds the result register and, once the input
// register is also occupied, raises o_stall.
`timescale 1ns / 1ps
`default_nettype none

module acpi_embedded_controller_interface (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_opcode,
    input  wire logic [7:0] i_local_address,
    input  wire logic [7:0] i_data_in,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [7:0] o_read_data,
    output logic            o_sci_pending,
    output logic            o_protocol_error
);
    import acpi_ec_pkg::*;

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [2:0] r_op;
    logic [7:0] r_addr;
    logic [7:0] r_data;

    // ---------------- result register ----------------
    logic       r_out_valid;
    logic [7:0] r_rd;
    logic       r_sci;
    logic       r_err;

    // ---------------- protocol state ----------------
    t_phase     r_phase, n_phase;
    logic [7:0] r_lat,  n_lat;      // latched address
    logic [7:0] r_ob,   n_ob;       // output buffer byte
    logic       r_ob_mem, n_ob_mem; // buffer byte lives in the space read register
    logic       r_obf,  n_obf;
    logic       r_burst, n_burst;

    logic       w_adv;   // result register free to take a beat
    logic       w_work;  // a beat is processed this cycle
    t_op        w_op;
    logic [7:0] w_ob_val;
    logic [7:0] n_rd;
    logic       n_sci;
    logic       n_err;

    t_qf_ctrl   w_qf_ctrl;
    t_qf_stat   w_qf_stat;
    logic [7:0] w_qf_head;

    t_sp_ctrl   w_sp_ctrl;
    logic [7:0] w_sp_waddr;
    logic [7:0] w_sp_wdata;
    logic [7:0] w_sp_rdata;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_work  = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;
    assign w_op    = t_op'(r_op);

    // Current output buffer contents, wherever they are held
    assign w_ob_val = r_ob_mem ? w_sp_rdata : r_ob;

    acpi_ec_space u_space (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_sp_ctrl),
        .i_waddr (w_sp_waddr),
        .i_wdata (w_sp_wdata),
        .i_raddr (r_data),
        .o_rdata (w_sp_rdata)
    );

    acpi_ec_qfifo u_qfifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_qf_ctrl),
        .i_wdata     (r_data),
        .o_head_data (w_qf_head),
        .o_stat      (w_qf_stat)
    );

    // Capture a beat whenever the input register is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op   <= i_opcode;
            r_addr <= i_local_address;
            r_data <= i_data_in;
        end
    end

    // Protocol phase: next-state logic
    always_comb begin
        n_phase = r_phase;
        if (w_work) begin
            unique case (w_op)
                OP_WR_CMD: begin
                    // any command drops an unfinished sequence
                    unique case (r_data)
                        CMD_READ:  n_phase = PH_RD_ADDR;
                        CMD_WRITE: n_phase = PH_WR_ADDR;
                        default:   n_phase = PH_IDLE;
                    endcase
                end
                OP_WR_DATA: begin
                    unique case (r_phase)
                        PH_IDLE:     n_phase = PH_IDLE;
                        PH_RD_ADDR:  n_phase = PH_IDLE;
                        PH_WR_ADDR:  n_phase = PH_WR_VALUE;
                        PH_WR_VALUE: n_phase = PH_IDLE;
                    endcase
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Beat actions: result fields, buffer, burst, space and FIFO controls
    always_comb begin
        n_rd        = 8'h00;
        n_err       = 1'b0;
        n_lat       = r_lat;
        n_ob        = r_ob;
        n_ob_mem    = r_ob_mem;
        n_obf       = r_obf;
        n_burst     = r_burst;
        w_qf_ctrl   = '0;
        w_sp_ctrl   = '0;
        w_sp_waddr  = r_addr;
        w_sp_wdata  = r_data;
        if (w_work) begin
            unique case (w_op)
                OP_RD_STATUS: begin
                    n_rd[ST_OBF_BIT]   = r_obf;
                    n_rd[ST_BURST_BIT] = r_burst;
                    n_rd[ST_SCI_BIT]   = !w_qf_stat.empty;
                end
                OP_WR_CMD: begin
                    n_err = (r_phase != PH_IDLE);
                    unique case (r_data)
                        CMD_READ, CMD_WRITE: ;
                        CMD_BURST_ON: begin
                            n_burst  = 1'b1;
                            n_ob     = BURST_GRANT;
                            n_ob_mem = 1'b0;
                            n_obf    = 1'b1;
                        end
                        CMD_BURST_OFF: n_burst = 1'b0;
                        CMD_QUERY: begin
                            // pop the oldest index, or answer zero when none waits
                            w_qf_ctrl.pop = !w_qf_stat.empty;
                            n_ob     = w_qf_stat.empty ? 8'h00 : w_qf_head;
                            n_ob_mem = 1'b0;
                            n_obf    = 1'b1;
                        end
                        default: n_err = 1'b1;
                    endcase
                end
                OP_RD_DATA: begin
                    if (r_obf) begin
                        n_rd  = w_ob_val;
                        n_obf = 1'b0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                OP_WR_DATA: begin
                    unique case (r_phase)
                        PH_IDLE: n_err = 1'b1;
                        PH_RD_ADDR: begin
                            // answer arrives in the space read register next edge
                            n_lat           = r_data;
                            w_sp_ctrl.rd_en = 1'b1;
                            n_ob_mem        = 1'b1;
                            n_obf           = 1'b1;
                        end
                        PH_WR_ADDR: n_lat = r_data;
                        PH_WR_VALUE: begin
                            w_sp_ctrl.wr_en = 1'b1;
                            w_sp_waddr      = r_lat;
                        end
                    endcase
                end
                OP_POST_QUERY: begin
                    if (r_data == 8'h00 || w_qf_stat.full) begin
                        n_err = 1'b1;
                    end else begin
                        w_qf_ctrl.push = 1'b1;
                    end
                end
                OP_LOCAL_WR: w_sp_ctrl.wr_en = 1'b1;
                default: ;
            endcase
        end
        // FIFO occupancy after this beat
        n_sci = w_qf_ctrl.push || (!w_qf_stat.empty && !(w_qf_ctrl.pop && w_qf_stat.last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_lat    <= 8'h00;
            r_ob     <= 8'h00;
            r_ob_mem <= 1'b0;
            r_obf    <= 1'b0;
            r_burst  <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_lat    <= n_lat;
            r_ob     <= n_ob;
            r_ob_mem <= n_ob_mem;
            r_obf    <= n_obf;
            r_burst  <= n_burst;
        end
    end

    // Result register: advance when free or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_work) begin
            r_rd  <= n_rd;
            r_sci <= n_sci;
            r_err <= n_err;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_data      = r_rd;
    assign o_sci_pending    = r_sci;
    assign o_protocol_error = r_err;

endmodule : acpi_embedded_controller_interface

`default_nettype wire

FILE: src/acpi_ec_checker.sv
// Port-level checker for the embedded-controller host interface, bound to
// the top level. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module acpi_ec_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [2:0] i_opcode,
    input wire logic [7:0] i_local_address,
    input wire logic [7:0] i_data_in,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_read_data,
    input wire logic       o_sci_pending,
    input wire logic       o_protocol_error
);

    // Nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data)
            && $stable(o_sci_pending) && $stable(o_protocol_error))
        else $error("stalled result beat changed");

    // Input back-pressure only while the output side is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output stall");

    // An erroneous access never returns data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_protocol_error |-> o_read_data == 8'h00)
        else $error("error beat carries nonzero data");

endmodule : acpi_ec_checker

bind acpi_embedded_controller_interface acpi_ec_checker u_acpi_ec_checker (.*);

`default_nettype wire

FILE: tb/sv/ec_host_checker.sv
// Scoreboard for the embedded-controller host interface: watches both channels,
// predicts each answer from its own copy of the controller state, and compares.
// Depends on acpi_ec_pkg for opcodes, command bytes, phases and status bits.
`timescale 1ns / 1ps

module ec_host_checker
    import acpi_ec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_local_address,
    input  logic [7:0] i_data_in,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_read_data,
    input  logic       i_sci_pending,
    input  logic       i_protocol_error,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_in,
    output int         o_beats_out,
    output int         o_error_pulses,
    output int         o_fifo_overflows
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       sci;
        logic       err;
    } t_port_answer;

    t_port_answer port_answers_due [$];

    // mirror of the controller state
    logic [7:0] space_image [SPACE_DEPTH];
    t_phase     phase_now;
    logic [7:0] addr_latch;
    logic [7:0] obuf;
    logic       obuf_full;
    logic       burst_on;
    logic [7:0] event_queue [QUERY_DEPTH];
    int         event_count;
    int         event_head;

    task report_mismatch(input string detail);
        $display("[%0t] mismatch: %s", $realtime, detail);
        o_fail_count++;
    endtask

    task predict_port_answer(
        input  logic [2:0]   op,
        input  logic [7:0]   addr,
        input  logic [7:0]   data,
        output t_port_answer ans
    );
        ans = '0;
        case (op)
            OP_RD_STATUS: begin
                ans.read_data[ST_OBF_BIT]   = obuf_full;
                ans.read_data[ST_BURST_BIT] = burst_on;
                ans.read_data[ST_SCI_BIT]   = (event_count > 0);
            end
            OP_WR_CMD: begin
                // a command always drops an unfinished sequence
                ans.err   = (phase_now != PH_IDLE);
                phase_now = PH_IDLE;
                case (data)
                    CMD_READ:      phase_now = PH_RD_ADDR;
                    CMD_WRITE:     phase_now = PH_WR_ADDR;
                    CMD_BURST_ON: begin
                        burst_on  = 1'b1;
                        obuf      = BURST_GRANT;
                        obuf_full = 1'b1;
                    end
                    CMD_BURST_OFF: burst_on = 1'b0;
                    CMD_QUERY: begin
                        obuf_full = 1'b1;
                        if (event_count > 0) begin
                            obuf       = event_queue[event_head];
                            event_head = (event_head + 1) % QUERY_DEPTH;
                            event_count--;
                        end else begin
                            obuf = 8'h00;
                        end
                    end
                    default:       ans.err = 1'b1;
                endcase
            end
            OP_RD_DATA: begin
                if (obuf_full) begin
                    ans.read_data = obuf;
                    obuf_full     = 1'b0;
                end else begin
                    ans.err = 1'b1;
                end
            end
            OP_WR_DATA: begin
                case (phase_now)
                    PH_RD_ADDR: begin
                        addr_latch = data;
                        obuf       = space_image[data];
                        obuf_full  = 1'b1;
                        phase_now  = PH_IDLE;
                    end
                    PH_WR_ADDR: begin
                        addr_latch = data;
                        phase_now  = PH_WR_VALUE;
                    end
                    PH_WR_VALUE: begin
                        space_image[addr_latch] = data;
                        phase_now               = PH_IDLE;
                    end
                    default:     ans.err = 1'b1;
                endcase
            end
            OP_POST_QUERY: begin
                if (data == 8'h00) begin
                    ans.err = 1'b1;
                end else if (event_count >= QUERY_DEPTH) begin
                    ans.err = 1'b1;
                    o_fifo_overflows++;
                end else begin
                    event_queue[(event_head + event_count) % QUERY_DEPTH] = data;
                    event_count++;
                end
            end
            OP_LOCAL_WR:   space_image[addr] = data;
            default:       ;
        endcase
        ans.sci = (event_count > 0);
    endtask

    always @(posedge i_clk) begin
        t_port_answer due;
        t_port_answer ans;
        if (!i_rst_n) begin
            for (int k = 0; k < SPACE_DEPTH; k++) space_image[k] = 8'h00;
            for (int k = 0; k < QUERY_DEPTH; k++) event_queue[k] = 8'h00;
            phase_now   = PH_IDLE;
            addr_latch  = 8'h00;
            obuf        = 8'h00;
            obuf_full   = 1'b0;
            burst_on    = 1'b0;
            event_count = 0;
            event_head  = 0;
            port_answers_due.delete();
            o_pending   = 0;
        end else begin
            // results first: the answer leaving now belongs to an older beat
            if (i_out_valid && !i_out_stall) begin
                o_beats_out++;
                if (port_answers_due.size() == 0) begin
                    report_mismatch($sformatf("answer with nothing pending, read_data %02h",
                                              i_read_data));
                end else begin
                    due = port_answers_due.pop_front();
                    if (i_read_data !== due.read_data)
                        report_mismatch($sformatf("answer %0d read_data %02h, want %02h",
                                                  o_beats_out, i_read_data, due.read_data));
                    if (i_sci_pending !== due.sci)
                        report_mismatch($sformatf("answer %0d sci_pending %b, want %b",
                                                  o_beats_out, i_sci_pending, due.sci));
                    if (i_protocol_error !== due.err)
                        report_mismatch($sformatf("answer %0d protocol_error %b, want %b",
                                                  o_beats_out, i_protocol_error, due.err));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_port_answer(i_opcode, i_local_address, i_data_in, ans);
                port_answers_due.push_back(ans);
                o_beats_in++;
                if (ans.err) o_error_pulses++;
            end
            o_pending = port_answers_due.size();
        end
    end

endmodule

FILE: tb/sv/testbench.sv
// Top of the host-interface testbench: clock, reset, stimulus and verdict.
// Depends on acpi_ec_pkg, ec_host_checker and the acpi_embedded_controller_interface RTL.
`timescale 1ns / 1ps

module testbench;
    import acpi_ec_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int ITEM_TARGET     = 400;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_CYCLES = 200_000;

    // opcodes the block must ignore
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // command bytes that decode to nothing
    localparam logic [7:0] BAD_CMD_ZEROS = 8'h00;
    localparam logic [7:0] BAD_CMD_ONES  = 8'hFF;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       i_stall;
    logic [2:0] i_opcode;
    logic [7:0] i_local_address;
    logic [7:0] i_data_in;
    wire        o_stall;
    wire        o_valid;
    wire  [7:0] o_read_data;
    wire        o_sci_pending;
    wire        o_protocol_error;

    int fail_count;
    int pending;
    int beats_in;
    int beats_out;
    int error_pulses;
    int fifo_overflows;

    // when set, both sides run back to back without idle cycles
    logic steady;
    int   beats_sent;

    acpi_embedded_controller_interface dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_local_address  (i_local_address),
        .i_data_in        (i_data_in),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_read_data      (o_read_data),
        .o_sci_pending    (o_sci_pending),
        .o_protocol_error (o_protocol_error)
    );

    ec_host_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_opcode         (i_opcode),
        .i_local_address  (i_local_address),
        .i_data_in        (i_data_in),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_read_data      (o_read_data),
        .i_sci_pending    (o_sci_pending),
        .i_protocol_error (o_protocol_error),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_beats_in       (beats_in),
        .o_beats_out      (beats_out),
        .o_error_pulses   (error_pulses),
        .o_fifo_overflows (fifo_overflows)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every beat waiting out both
    // the longest sender gap and the longest receiver stall).
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

    // Present one beat on the input channel. Draw an idle gap first, then hold
    // valid and payload steady until the block takes the beat.
    task send_beat(input logic [2:0] op, input logic [7:0] addr, input logic [7:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_opcode        <= op;
        i_local_address <= addr;
        i_data_in       <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    // Drop valid and hold the sender until every predicted answer has come back.
    task hold_until_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Bias addresses toward a small window so reads hit bytes written earlier.
    function automatic logic [7:0] pick_address();
        if ($urandom_range(0, 99) < 75) return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_command();
        case ($urandom_range(0, 5))
            0:       return CMD_READ;
            1:       return CMD_WRITE;
            2:       return CMD_BURST_ON;
            3:       return CMD_BURST_OFF;
            4:       return CMD_QUERY;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task run_directed_checks();
        // fresh out of reset: empty status, then every misuse of the data port
        send_beat(OP_RD_STATUS, 8'h00, 8'h00);
        send_beat(OP_RD_DATA, 8'h00, 8'h00);          // OBF clear
        send_beat(OP_WR_DATA, 8'h00, 8'hFF);          // data write while idle
        send_beat(OP_WR_CMD, 8'h00, BAD_CMD_ZEROS);   // unknown command
        send_beat(OP_WR_CMD, 8'h00, BAD_CMD_ONES);
        // firmware fills both ends of the space
        send_beat(OP_LOCAL_WR, 8'hFF, 8'hFF);
        send_beat(OP_LOCAL_WR, 8'h00, 8'h5A);
        // host read of the top byte
        send_beat(OP_WR_CMD, 8'h00, CMD_READ);
        send_beat(OP_WR_DATA, 8'h00, 8'hFF);
        send_beat(OP_RD_STATUS, 8'h00, 8'h00);
        send_beat(OP_RD_DATA, 8'h00, 8'h00);
        // write sequence cut short by a read command, which still runs
        send_beat(OP_WR_CMD, 8'h00, CMD_WRITE);
        send_beat(OP_WR_DATA, 8'h00, 8'h00);
        send_beat(OP_WR_CMD, 8'h00, CMD_READ);
        send_beat(OP_WR_DATA, 8'h00, 8'h00);
        // burst acknowledge overwrites the unread answer
        send_beat(OP_WR_CMD, 8'h00, CMD_BURST_ON);
        send_beat(OP_RD_STATUS, 8'h00, 8'h00);
        send_beat(OP_RD_DATA, 8'h00, 8'h00);
        send_beat(OP_WR_CMD, 8'h00, CMD_BURST_OFF);
        // events: zero index rejected, two real ones, then drain past empty
        send_beat(OP_POST_QUERY, 8'h00, 8'h00);
        send_beat(OP_POST_QUERY, 8'h00, 8'hFF);
        send_beat(OP_POST_QUERY, 8'h00, 8'h01);
        send_beat(OP_RD_STATUS, 8'h00, 8'h00);
        send_beat(OP_WR_CMD, 8'h00, CMD_QUERY);
        send_beat(OP_RD_DATA, 8'h00, 8'h00);
        send_beat(OP_WR_CMD, 8'h00, CMD_QUERY);
        send_beat(OP_WR_CMD, 8'h00, CMD_QUERY);       // empty: answers zero
        send_beat(OP_RD_DATA, 8'h00, 8'h00);
        // spare opcodes do nothing
        send_beat(OP_SPARE_6, 8'hFF, 8'hFF);
        send_beat(OP_SPARE_7, 8'h00, 8'h00);
    endtask

    task run_random_traffic();
        int goal;
        int roll;
        goal = beats_sent + ITEM_TARGET;
        while (beats_sent < goal) begin
            roll = $urandom_range(0, 99);
            // switch between gappy and back-to-back stretches now and then
            if ($urandom_range(0, 7) == 0) steady = ~steady;
            if ($urandom_range(0, 19) == 0) hold_until_drained();
            if (roll < 20) begin
                // host read transaction, optionally polling status in between
                send_beat(OP_WR_CMD, 8'($urandom), CMD_READ);
                if ($urandom_range(0, 1)) send_beat(OP_RD_STATUS, 8'($urandom), 8'($urandom));
                send_beat(OP_WR_DATA, 8'($urandom), pick_address());
                send_beat(OP_RD_STATUS, 8'($urandom), 8'($urandom));
                send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
            end else if (roll < 40) begin
                // host write transaction
                send_beat(OP_WR_CMD, 8'($urandom), CMD_WRITE);
                send_beat(OP_WR_DATA, 8'($urandom), pick_address());
                send_beat(OP_WR_DATA, 8'($urandom), 8'($urandom));
            end else if (roll < 50) begin
                send_beat(OP_LOCAL_WR, pick_address(), 8'($urandom));
            end else if (roll < 60) begin
                // a few firmware events, now and then a zero index
                repeat ($urandom_range(1, 3))
                    send_beat(OP_POST_QUERY, 8'($urandom),
                              ($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            end else if (roll < 64) begin
                // event storm: fill the FIFO to capacity or overrun it, then drain it and one more
                repeat ($urandom_range(QUERY_DEPTH, QUERY_DEPTH + 2))
                    send_beat(OP_POST_QUERY, 8'($urandom), 8'($urandom_range(1, 255)));
                repeat (QUERY_DEPTH + 1) begin
                    send_beat(OP_WR_CMD, 8'($urandom), CMD_QUERY);
                    send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
                end
            end else if (roll < 74) begin
                send_beat(OP_WR_CMD, 8'($urandom), CMD_QUERY);
                send_beat(OP_RD_STATUS, 8'($urandom), 8'($urandom));
                send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
            end else if (roll < 81) begin
                send_beat(OP_WR_CMD, 8'($urandom), CMD_BURST_ON);
                send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
                send_beat(OP_RD_STATUS, 8'($urandom), 8'($urandom));
                send_beat(OP_WR_CMD, 8'($urandom), CMD_BURST_OFF);
                send_beat(OP_RD_STATUS, 8'($urandom), 8'($urandom));
            end else if (roll < 90) begin
                // broken sequences
                case ($urandom_range(0, 2))
                    0: begin
                        send_beat(OP_WR_CMD, 8'($urandom), pick_command());
                        send_beat(OP_WR_CMD, 8'($urandom), pick_command());
                    end
                    1: begin
                        send_beat(OP_WR_CMD, 8'($urandom), CMD_WRITE);
                        send_beat(OP_WR_DATA, 8'($urandom), pick_address());
                        send_beat(OP_WR_CMD, 8'($urandom), pick_command());
                    end
                    default: begin
                        send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
                        send_beat(OP_RD_DATA, 8'($urandom), 8'($urandom));
                        send_beat(OP_WR_DATA, 8'($urandom), 8'($urandom));
                    end
                endcase
            end else begin
                // pure noise, spare opcodes included
                send_beat(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
            end
        end
    endtask

    // Receiver: draw a stall length per answer, hold stall for it, then take
    // the next answer. The stall length is drawn as zero during steady stretches.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_opcode        = OP_RD_STATUS;
        i_local_address = 8'h00;
        i_data_in       = 8'h00;
        steady          = 1'b0;
        beats_sent      = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_checks();
        // pause the sender once with everything in flight drained
        hold_until_drained();
        run_random_traffic();

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("summary: %0d accesses sent, %0d answers checked, %0d error pulses expected",
                 beats_in, beats_out, error_pulses);
        $display("summary: query FIFO overrun %0d times over read, write, burst and event mix",
                 fifo_overflows);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
